// ----- rtl/mot_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mot_pkg
// Shared widths, payload types and datapath command codes of the 1-tree builder.
// ----------------------------------------------------------------------------
package mot_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int MAX_EDGES    = 512;
	localparam int WEIGHT_BITS  = 16;

	localparam int VTX_W   = $clog2(MAX_VERTICES);
	localparam int N_W     = $clog2(MAX_VERTICES + 1);
	localparam int EA_W    = $clog2(MAX_EDGES);
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
	localparam int TOTAL_W = 21;
	localparam int DEG_W   = N_W;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] STAT_IMPOSED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FREE    = 2'd2;

	typedef struct packed {
		logic [4:0]  edge_end_a;
		logic [4:0]  edge_end_b;
		logic [15:0] edge_weight;
		logic [1:0]  edge_status;
		logic        last_edge;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  tree_end_a;
		logic [4:0]  tree_end_b;
		logic [15:0] tree_edge_weight;
		logic [20:0] total_weight;
		logic        built_ok;
		logic [5:0]  branch_vertex;
		logic        last_result;
	} out_item_t;

	typedef struct packed {
		logic [VTX_W-1:0]       a;
		logic [VTX_W-1:0]       b;
		logic [WEIGHT_BITS-1:0] w;
		logic [STAT_W-1:0]      st;
	} edge_rec_t;

	typedef struct packed {
		logic [VTX_W-1:0]       a;
		logic [VTX_W-1:0]       b;
		logic [WEIGHT_BITS-1:0] w;
	} tree_rec_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LOAD,
		OP_CHK,
		OP_SHIFT,
		OP_INS,
		OP_INIT,
		OP_SEX,
		OP_LBL_A,
		OP_LBL_B,
		OP_LBL_CMP,
		OP_TAKE,
		OP_DEG_A,
		OP_DEG_B,
		OP_MRG_WR,
		OP_BR_END,
		OP_BR_CHK,
		OP_OUT_LD,
		OP_OUT_FAIL
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [EA_W-1:0]  erd;
		logic [EA_W-1:0]  ewr;
		logic [VTX_W-1:0] vtx;
		logic [VTX_W-1:0] taddr;
		logic [N_W-1:0]   n;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic keep;
		logic w_less;
		logic touch_zero;
		logic imposed;
		logic free_e;
		logic label_eq;
		logic deg_gt2;
	} status_t;

endpackage
`default_nettype wire

// ----- rtl/min_one_tree_kruskal_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// min_one_tree_kruskal_top
// Minimum 1-tree builder: loads edges, sorts them, builds the tree, emits it.
// ----------------------------------------------------------------------------
// Load: one edge per cycle until the edge marked last; the input then stalls.
// Sort: every kept edge is inserted by weight into the sorted list, shifting heavier ones.
// Build: label init, then four scans of the sorted list; a take off vertex 0
// updates both degrees and merges the labels, a take at vertex 0 updates the
// degrees only, a free edge inside one component is rejected; then degree search, output.
// Reset clears control state only; vertex_count returns to 32.
module min_one_tree_kruskal_top import mot_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	mot_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.in_last(in_data.last_edge), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .status(status), .cmd(cmd));

	mot_dp u_dp (
		.clk(clk), .cmd(cmd), .in_data(in_data), .status(status),
		.out_data(out_data));

endmodule
`default_nettype wire

// ----- rtl/mot_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mot_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/mot_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mot_dp
// Datapath: edge store, sorted list, component labels, degrees, tree list,
// running total and the output register.
// ----------------------------------------------------------------------------
module mot_dp import mot_pkg::*; (
	input  wire logic      clk,
	input  wire cmd_t      cmd,
	input  wire in_item_t  in_data,
	output status_t        status,
	output out_item_t      out_data
);

	edge_rec_t in_rec, e_rd, s_rd, s_wdata;
	tree_rec_t t_rd, t_wdata;
	logic [VTX_W-1:0] l_rd, l_raddr, l_wdata;
	logic [DEG_W-1:0] d_rd, d_wdata;
	logic [VTX_W-1:0] d_raddr, d_waddr;
	logic s_we, l_we, d_we;

	edge_rec_t        cur_q;
	logic [VTX_W-1:0] la_q, lb_q;
	logic [TOTAL_W-1:0] total_q;
	logic [N_W-1:0]   branch_q;
	out_item_t        out_q;

	assign in_rec = '{a: in_data.edge_end_a, b: in_data.edge_end_b,
		w: in_data.edge_weight, st: in_data.edge_status};

	mot_ram #(.WIDTH($bits(edge_rec_t)), .DEPTH(MAX_EDGES)) u_estore (
		.clk(clk), .we(cmd.op == OP_LOAD), .waddr(cmd.ewr), .wdata(in_rec),
		.raddr(cmd.erd), .rdata(e_rd));

	assign s_we    = (cmd.op == OP_INS) || (cmd.op == OP_SHIFT && status.w_less);
	assign s_wdata = (cmd.op == OP_INS) ? cur_q : s_rd;

	mot_ram #(.WIDTH($bits(edge_rec_t)), .DEPTH(MAX_EDGES)) u_sorted (
		.clk(clk), .we(s_we), .waddr(cmd.ewr), .wdata(s_wdata),
		.raddr(cmd.erd), .rdata(s_rd));

	always_comb begin
		case (cmd.op)
			OP_LBL_A: l_raddr = cur_q.a;
			OP_LBL_B: l_raddr = cur_q.b;
			default:  l_raddr = cmd.vtx;
		endcase
	end
	assign l_we    = (cmd.op == OP_INIT) || (cmd.op == OP_MRG_WR && l_rd == lb_q);
	assign l_wdata = (cmd.op == OP_INIT) ? cmd.vtx : la_q;

	mot_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_label (
		.clk(clk), .we(l_we), .waddr(cmd.vtx), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rd));

	always_comb begin
		case (cmd.op)
			OP_TAKE:  d_raddr = cur_q.a;
			OP_DEG_A: d_raddr = cur_q.b;
			default:  d_raddr = cmd.vtx;
		endcase
		case (cmd.op)
			OP_DEG_A: d_waddr = cur_q.a;
			OP_DEG_B: d_waddr = cur_q.b;
			default:  d_waddr = cmd.vtx;
		endcase
	end
	assign d_we    = (cmd.op == OP_INIT) || (cmd.op == OP_DEG_A) || (cmd.op == OP_DEG_B);
	assign d_wdata = (cmd.op == OP_INIT) ? '0 : d_rd + DEG_W'(1);

	mot_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_degree (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rd));

	assign t_wdata = '{a: cur_q.a, b: cur_q.b, w: cur_q.w};

	mot_ram #(.WIDTH($bits(tree_rec_t)), .DEPTH(MAX_VERTICES)) u_tlist (
		.clk(clk), .we(cmd.op == OP_TAKE), .waddr(cmd.taddr), .wdata(t_wdata),
		.raddr(cmd.taddr), .rdata(t_rd));

	always_comb begin
		status.keep = (e_rd.st == STAT_IMPOSED || e_rd.st == STAT_FREE)
			&& ({1'b0, e_rd.a} < cmd.n) && ({1'b0, e_rd.b} < cmd.n)
			&& (e_rd.a != e_rd.b);
		status.w_less     = cur_q.w < s_rd.w;
		status.touch_zero = (s_rd.a == '0) || (s_rd.b == '0);
		status.imposed    = s_rd.st == STAT_IMPOSED;
		status.free_e     = s_rd.st == STAT_FREE;
		status.label_eq   = l_rd == la_q;
		status.deg_gt2    = d_rd > DEG_W'(2);
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CHK:     cur_q <= e_rd;
			OP_SEX:     cur_q <= s_rd;
			OP_LBL_B:   la_q <= l_rd;
			OP_LBL_CMP: lb_q <= l_rd;
			OP_INIT:    total_q <= '0;
			OP_TAKE:    total_q <= total_q + TOTAL_W'(cur_q.w);
			OP_BR_END:  branch_q <= cmd.n;
			OP_BR_CHK: begin
				if (status.deg_gt2) begin
					branch_q <= N_W'(cmd.vtx);
				end
			end
			OP_OUT_LD: begin
				out_q.tree_end_a       <= t_rd.a;
				out_q.tree_end_b       <= t_rd.b;
				out_q.tree_edge_weight <= t_rd.w;
				out_q.total_weight     <= total_q;
				out_q.built_ok         <= 1'b1;
				out_q.branch_vertex    <= branch_q;
				out_q.last_result      <= cmd.last;
			end
			OP_OUT_FAIL: begin
				out_q <= '{tree_end_a: '0, tree_end_b: '0, tree_edge_weight: '0,
					total_weight: '0, built_ok: 1'b0, branch_vertex: '0,
					last_result: 1'b1};
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// ----- rtl/mot_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mot_ctrl
// Sequencer: load, insertion sort, four scan phases, degree search, output.
// ----------------------------------------------------------------------------
module mot_ctrl import mot_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_last,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire logic            cfg_we,
	input  wire logic [N_W-1:0]  cfg_wdata,
	input  wire status_t         status,
	output cmd_t                 cmd
);

	typedef enum logic [4:0] {
		S_LOAD, S_RDE, S_CHK, S_CMP, S_INS, S_INIT, S_SRD, S_SEX, S_LA, S_LB,
		S_LCMP, S_TAKE, S_DA, S_DB, S_MR, S_MW, S_BRD, S_BCK, S_ORD, S_OLD,
		S_FAIL, S_OWAIT
	} state_t;

	state_t state_q;
	logic [N_W-1:0]    vcount_q, v_q, tsize_q, o_q;
	logic [ECNT_W-1:0] cnt_q, i_q, j_q, kept_q, k_q;
	logic [1:0]        phase_q;
	logic              fail_q;

	logic [N_W-1:0]    n, n_m2;
	logic [ECNT_W-1:0] i_inc, kept_m1, j_m2;
	logic              match, scan_end;

	always_comb begin
		if (vcount_q < N_W'(3)) begin
			n = N_W'(3);
		end else if (vcount_q > N_W'(MAX_VERTICES)) begin
			n = N_W'(MAX_VERTICES);
		end else begin
			n = vcount_q;
		end
	end
	assign n_m2    = n - N_W'(2);
	assign i_inc   = i_q + ECNT_W'(1);
	assign kept_m1 = kept_q - ECNT_W'(1);
	assign j_m2    = j_q - ECNT_W'(2);

	always_comb begin
		case (phase_q)
			2'd0:    match = !status.touch_zero && status.imposed;
			2'd1:    match = !status.touch_zero && status.free_e;
			2'd2:    match = status.touch_zero && status.imposed;
			default: match = status.touch_zero && status.free_e;
		endcase
		case (phase_q)
			2'd1:    scan_end = (k_q == kept_q) || (tsize_q == n_m2);
			2'd3:    scan_end = (k_q == kept_q) || (tsize_q == n);
			default: scan_end = k_q == kept_q;
		endcase
	end

	assign in_stall = state_q != S_LOAD;

	always_comb begin
		cmd       = '0;
		cmd.op    = OP_IDLE;
		cmd.n     = n;
		cmd.vtx   = v_q[VTX_W-1:0];
		cmd.taddr = tsize_q[VTX_W-1:0];
		cmd.last  = (o_q + N_W'(1)) == tsize_q;
		cmd.erd   = k_q[EA_W-1:0];
		cmd.ewr   = j_q[EA_W-1:0];
		case (state_q)
			S_LOAD: begin
				cmd.ewr = cnt_q[EA_W-1:0];
				if (in_valid && cnt_q < ECNT_W'(MAX_EDGES)) begin
					cmd.op = OP_LOAD;
				end
			end
			S_RDE:  cmd.erd = i_q[EA_W-1:0];
			S_CHK: begin
				cmd.op  = OP_CHK;
				cmd.erd = kept_m1[EA_W-1:0];
			end
			S_CMP: begin
				cmd.op  = OP_SHIFT;
				cmd.erd = j_m2[EA_W-1:0];
			end
			S_INS:  cmd.op = OP_INS;
			S_INIT: cmd.op = OP_INIT;
			S_SEX:  cmd.op = OP_SEX;
			S_LA:   cmd.op = OP_LBL_A;
			S_LB:   cmd.op = OP_LBL_B;
			S_LCMP: cmd.op = OP_LBL_CMP;
			S_TAKE: cmd.op = OP_TAKE;
			S_DA:   cmd.op = OP_DEG_A;
			S_DB:   cmd.op = OP_DEG_B;
			S_MW:   cmd.op = OP_MRG_WR;
			S_BRD: begin
				if (v_q == n) begin
					cmd.op = OP_BR_END;
				end
			end
			S_BCK:  cmd.op = OP_BR_CHK;
			S_ORD:  cmd.taddr = o_q[VTX_W-1:0];
			S_OLD: begin
				cmd.op    = OP_OUT_LD;
				cmd.taddr = o_q[VTX_W-1:0];
			end
			S_FAIL: cmd.op = OP_OUT_FAIL;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			vcount_q  <= N_W'(MAX_VERTICES);
			cnt_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			kept_q    <= '0;
			k_q       <= '0;
			v_q       <= '0;
			tsize_q   <= '0;
			o_q       <= '0;
			phase_q   <= '0;
			fail_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (cnt_q < ECNT_W'(MAX_EDGES)) begin
							cnt_q <= cnt_q + ECNT_W'(1);
						end
						if (in_last) begin
							i_q     <= '0;
							kept_q  <= '0;
							state_q <= S_RDE;
						end
					end
				end
				S_RDE: state_q <= S_CHK;
				S_CHK: begin
					if (!status.keep) begin
						i_q     <= i_inc;
						v_q     <= '0;
						state_q <= (i_inc == cnt_q) ? S_INIT : S_RDE;
					end else begin
						j_q     <= kept_q;
						state_q <= (kept_q == '0) ? S_INS : S_CMP;
					end
				end
				S_CMP: begin
					if (status.w_less) begin
						j_q     <= j_q - ECNT_W'(1);
						state_q <= (j_q == ECNT_W'(1)) ? S_INS : S_CMP;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					kept_q  <= kept_q + ECNT_W'(1);
					i_q     <= i_inc;
					v_q     <= '0;
					state_q <= (i_inc == cnt_q) ? S_INIT : S_RDE;
				end
				S_INIT: begin
					v_q <= v_q + N_W'(1);
					if ((v_q + N_W'(1)) == n) begin
						tsize_q <= '0;
						phase_q <= '0;
						k_q     <= '0;
						fail_q  <= 1'b0;
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					if (scan_end) begin
						k_q <= '0;
						case (phase_q)
							2'd1: begin
								phase_q <= 2'd2;
								if (tsize_q != n_m2) begin
									state_q <= S_FAIL;
								end
							end
							2'd3: begin
								v_q     <= '0;
								state_q <= (tsize_q == n) ? S_BRD : S_FAIL;
							end
							default: phase_q <= phase_q + 2'd1;
						endcase
					end else begin
						state_q <= S_SEX;
					end
				end
				S_SEX: begin
					if (!match) begin
						k_q     <= k_q + ECNT_W'(1);
						state_q <= S_SRD;
					end else begin
						case (phase_q)
							2'd0: state_q <= (tsize_q >= n_m2) ? S_FAIL : S_LA;
							2'd1: state_q <= S_LA;
							2'd2: state_q <= (tsize_q >= n) ? S_FAIL : S_TAKE;
							default: state_q <= S_TAKE;
						endcase
					end
				end
				S_LA: state_q <= S_LB;
				S_LB: state_q <= S_LCMP;
				S_LCMP: begin
					// a free edge inside one component would close a cycle
					if (phase_q == 2'd1 && status.label_eq) begin
						k_q     <= k_q + ECNT_W'(1);
						state_q <= S_SRD;
					end else begin
						state_q <= S_TAKE;
					end
				end
				S_TAKE: begin
					tsize_q <= tsize_q + N_W'(1);
					state_q <= S_DA;
				end
				S_DA: state_q <= S_DB;
				S_DB: begin
					v_q <= '0;
					if (phase_q < 2'd2) begin
						state_q <= S_MR;
					end else begin
						k_q     <= k_q + ECNT_W'(1);
						state_q <= S_SRD;
					end
				end
				S_MR: begin
					if (v_q == n) begin
						k_q     <= k_q + ECNT_W'(1);
						state_q <= S_SRD;
					end else begin
						state_q <= S_MW;
					end
				end
				S_MW: begin
					v_q     <= v_q + N_W'(1);
					state_q <= S_MR;
				end
				S_BRD: begin
					o_q     <= '0;
					state_q <= (v_q == n) ? S_ORD : S_BCK;
				end
				S_BCK: begin
					if (status.deg_gt2) begin
						state_q <= S_ORD;
					end else begin
						v_q     <= v_q + N_W'(1);
						state_q <= S_BRD;
					end
				end
				S_ORD: state_q <= S_OLD;
				S_OLD: begin
					out_valid <= 1'b1;
					state_q   <= S_OWAIT;
				end
				S_FAIL: begin
					fail_q    <= 1'b1;
					out_valid <= 1'b1;
					state_q   <= S_OWAIT;
				end
				S_OWAIT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (fail_q || (o_q + N_W'(1)) == tsize_q) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							o_q     <= o_q + N_W'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- tb/mot_checker.sv -----
// ----------------------------------------------------------------------------
// mot_checker
// Watches the edge and tree channels of the 1-tree builder, predicts the
// tree of every edge set and compares each transfer on the tree channel.
// ----------------------------------------------------------------------------
module mot_checker import mot_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire in_item_t   in_data,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire out_item_t  out_data,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_wdata,
	output int              errors,
	output int              pending,
	output int              trees_seen,
	output int              fails_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [4:0]  st_a [MAX_EDGES];
	logic [4:0]  st_b [MAX_EDGES];
	logic [15:0] st_w [MAX_EDGES];
	logic [1:0]  st_s [MAX_EDGES];
	int          edge_cnt;
	logic [5:0]  vtx_count;

	int lab [MAX_VERTICES];
	int deg [MAX_VERTICES];
	int tl  [MAX_VERTICES];
	int tsz;

	out_item_t tree_q[$];

	task automatic report(input string what, input out_item_t got, input out_item_t exp_r);
		$display("[%0t] mismatch %s: got %h exp %h", $realtime, what, got, exp_r);
		errors++;
	endtask

	function automatic void take_into_tree(input int idx, input int n, input bit merge);
		int la, lb;
		tl[tsz] = idx;
		tsz++;
		deg[st_a[idx]]++;
		deg[st_b[idx]]++;
		if (merge) begin
			la = lab[st_a[idx]];
			lb = lab[st_b[idx]];
			for (int j = 0; j < n; j++)
				if (lab[j] == lb) lab[j] = la;
		end
	endfunction

	function automatic bit at_zero(input int idx);
		return st_a[idx] == 0 || st_b[idx] == 0;
	endfunction

	task automatic build_tree();
		int n, kept, j, idx, br;
		int ord [MAX_EDGES];
		logic [20:0] tot;
		bit ok;
		out_item_t r;
		n = (vtx_count < 3) ? 3 : (vtx_count > MAX_VERTICES) ? MAX_VERTICES : vtx_count;
		kept = 0;
		for (int i = 0; i < edge_cnt; i++) begin
			if (st_s[i] != STAT_IMPOSED && st_s[i] != STAT_FREE) continue;
			if (st_a[i] >= n || st_b[i] >= n || st_a[i] == st_b[i]) continue;
			// stable insertion: ties stay in arrival order
			j = kept;
			while (j > 0 && st_w[i] < st_w[ord[j-1]]) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = i;
			kept++;
		end
		for (int i = 0; i < n; i++) begin
			lab[i] = i;
			deg[i] = 0;
		end
		tsz = 0;
		ok = 1;
		for (int k = 0; k < kept && ok; k++) begin
			idx = ord[k];
			if (at_zero(idx) || st_s[idx] != STAT_IMPOSED) continue;
			if (tsz >= n - 2) ok = 0;
			else take_into_tree(idx, n, 1);
		end
		for (int k = 0; k < kept && ok && tsz < n - 2; k++) begin
			idx = ord[k];
			if (at_zero(idx) || st_s[idx] != STAT_FREE) continue;
			if (lab[st_a[idx]] == lab[st_b[idx]]) continue;
			take_into_tree(idx, n, 1);
		end
		if (tsz != n - 2) ok = 0;
		for (int k = 0; k < kept && ok; k++) begin
			idx = ord[k];
			if (!at_zero(idx) || st_s[idx] != STAT_IMPOSED) continue;
			if (tsz >= n) ok = 0;
			else take_into_tree(idx, n, 0);
		end
		for (int k = 0; k < kept && ok && tsz < n; k++) begin
			idx = ord[k];
			if (!at_zero(idx) || st_s[idx] != STAT_FREE) continue;
			take_into_tree(idx, n, 0);
		end
		if (tsz != n) ok = 0;
		if (!ok) begin
			r = '0;
			r.last_result = 1'b1;
			tree_q.push_back(r);
		end else begin
			tot = '0;
			for (int i = 0; i < tsz; i++) tot += 21'(st_w[tl[i]]);
			br = n;
			for (int i = n - 1; i >= 0; i--)
				if (deg[i] > 2) br = i;
			for (int i = 0; i < tsz; i++) begin
				r.tree_end_a       = st_a[tl[i]];
				r.tree_end_b       = st_b[tl[i]];
				r.tree_edge_weight = st_w[tl[i]];
				r.total_weight     = tot;
				r.built_ok         = 1'b1;
				r.branch_vertex    = 6'(br);
				r.last_result      = (i + 1 == tsz);
				tree_q.push_back(r);
			end
		end
		edge_cnt = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			edge_cnt = 0;
			vtx_count = 6'd32;
			tree_q.delete();
			errors = 0;
			pending <= 0;
			trees_seen <= 0;
			fails_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (tree_q.size() == 0) begin
					$display("[%0t] unexpected tree transfer %h", $realtime, out_data);
					errors++;
				end else begin
					exp_r = tree_q.pop_front();
					if (out_data.tree_end_a != exp_r.tree_end_a) report("tree_end_a", out_data, exp_r);
					if (out_data.tree_end_b != exp_r.tree_end_b) report("tree_end_b", out_data, exp_r);
					if (out_data.tree_edge_weight != exp_r.tree_edge_weight)
						report("tree_edge_weight", out_data, exp_r);
					if (out_data.total_weight != exp_r.total_weight)
						report("total_weight", out_data, exp_r);
					if (out_data.built_ok != exp_r.built_ok) report("built_ok", out_data, exp_r);
					if (out_data.branch_vertex != exp_r.branch_vertex)
						report("branch_vertex", out_data, exp_r);
					if (out_data.last_result != exp_r.last_result)
						report("last_result", out_data, exp_r);
					if (exp_r.last_result) begin
						if (exp_r.built_ok) trees_seen <= trees_seen + 1;
						else fails_seen <= fails_seen + 1;
					end
				end
			end
			if (cfg_we) vtx_count = cfg_wdata;
			if (in_valid && !in_stall) begin
				if (edge_cnt < MAX_EDGES) begin
					st_a[edge_cnt] = in_data.edge_end_a;
					st_b[edge_cnt] = in_data.edge_end_b;
					st_w[edge_cnt] = in_data.edge_weight;
					st_s[edge_cnt] = in_data.edge_status;
					edge_cnt++;
				end
				if (in_data.last_edge) build_tree();
			end
			pending <= tree_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Edge-set stimulus for the 1-tree builder: directed corner sets, a clamped
// vertex count, then random graphs at several vertex counts, with random gaps
// and stalls on both channels. Checking is done by mot_checker.
// ----------------------------------------------------------------------------
module tb_top import mot_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 200000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;
	logic       cfg_we;
	logic [5:0] cfg_wdata;

	int errors, pending, trees_seen, fails_seen;
	int gap_max;
	int sent;
	int idle_cycles;

	in_item_t edge_q[$];

	min_one_tree_kruskal_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	mot_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending), .trees_seen(trees_seen),
		.fails_seen(fails_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stall before each tree transfer
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = (gap_max == 0) ? 0 : $urandom_range(0, 12);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_edge(input in_item_t it);
		int n;
		n = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic push_edge(input int a, input int b, input int w, input int st);
		in_item_t it;
		it.edge_end_a  = 5'(a);
		it.edge_end_b  = 5'(b);
		it.edge_weight = 16'(w);
		it.edge_status = 2'(st);
		it.last_edge   = 1'b0;
		edge_q.push_back(it);
	endtask

	task automatic send_set();
		in_item_t it;
		edge_q[edge_q.size() - 1].last_edge = 1'b1;
		while (edge_q.size() > 0) begin
			it = edge_q.pop_front();
			send_edge(it);
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_vertices(input logic [5:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int rand_weight(input int mode);
		case (mode)
			0: return $urandom_range(0, 3);
			1: return ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(0, 1);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// random graph on n vertices; broken sets leave out the spanning edges
	task automatic rand_set(input int n, input bit broken);
		int wm, extra, a, b, st, j, r;
		in_item_t tmp;
		wm = $urandom_range(0, 3);
		if (!broken) begin
			for (int i = 2; i < n; i++) push_edge(i, $urandom_range(1, i - 1), rand_weight(wm), 2);
			push_edge($urandom_range(1, n - 1), 0, rand_weight(wm), 2);
			push_edge($urandom_range(1, n - 1), 0, rand_weight(wm), 2);
		end
		extra = $urandom_range(1, n + 2);
		for (int i = 0; i < extra; i++) begin
			a = $urandom_range(1, n - 1);
			b = $urandom_range(0, a - 1);
			r = $urandom_range(0, 19);
			st = (r < 2) ? 1 : (r < 4) ? 0 : (r == 4) ? 3 : 2;
			if ($urandom_range(0, 15) == 0) a = $urandom_range(0, 31);
			if ($urandom_range(0, 15) == 0) b = a;
			push_edge(a, b, rand_weight(wm), st);
		end
		for (int i = edge_q.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = edge_q[i];
			edge_q[i] = edge_q[j];
			edge_q[j] = tmp;
		end
		// endpoints in either order
		for (int i = 0; i < edge_q.size(); i++)
			if ($urandom_range(0, 3) == 0) begin
				a = edge_q[i].edge_end_a;
				edge_q[i].edge_end_a = edge_q[i].edge_end_b;
				edge_q[i].edge_end_b = 5'(a);
			end
		send_set();
	endtask

	initial begin
		int n;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		gap_max   = 12;
		sent      = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default 32 vertices with a tiny set: cannot build
		push_edge(31, 30, 65535, 2);
		push_edge(31, 31, 0, 2);
		push_edge(5, 0, 0, 3);
		push_edge(31, 0, 65535, 1);
		send_set();

		set_vertices(6'd3);
		push_edge(1, 0, 0, 2);
		push_edge(2, 0, 65535, 2);
		push_edge(2, 1, 65535, 1);
		push_edge(2, 1, 7, 0);
		push_edge(0, 2, 0, 2);
		send_set();
		// too many imposed edges off vertex 0
		push_edge(2, 1, 4, 1);
		push_edge(1, 2, 5, 1);
		push_edge(1, 0, 5, 2);
		send_set();
		// imposed edges at vertex 0 overflow the tree
		push_edge(2, 1, 9, 2);
		push_edge(1, 0, 3, 1);
		push_edge(2, 0, 3, 1);
		push_edge(0, 2, 3, 1);
		send_set();

		// clamped low, edges back to back
		set_vertices(6'd0);
		gap_max = 0;
		push_edge(2, 1, 100, 2);
		push_edge(1, 0, 100, 2);
		push_edge(2, 0, 100, 2);
		for (int i = 0; i < 8; i++) push_edge(2 - i % 2, i % 2, 0, 2);
		send_set();

		// well-formed random graphs at several sizes, some broken ones
		gap_max = 12;
		while (sent < 210) begin
			case ($urandom_range(0, 7))
				0: n = 3;
				1: n = 32;
				default: n = $urandom_range(4, 9);
			endcase
			if ($urandom_range(0, 9) == 0) n = 63;
			set_vertices(6'(n));
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			rand_set((n > 32) ? 32 : n, $urandom_range(0, 9) == 0);
			// pause until the whole tree is out
			if ($urandom_range(0, 4) == 0) wait_drained();
		end

		wait_drained();
		$display("sent %0d edges; %0d trees built and %0d failed builds checked",
			sent, trees_seen, fails_seen);
		$display("vertex counts from clamped low to clamped high, gaps and back to back");
		if (errors == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
